[sv/chfm_pkg.sv]
// Shared types, constants and the arctangent table for the compass heading block.
// No dependencies; every other file imports this package.
package chfm_pkg;

  localparam int unsigned ARCTAN_STAGES_DEF = 16;
  localparam int unsigned TABLE_LEN         = 24;

  // Vector width after pre-rotation plus CORDIC growth, and angle accumulator width
  localparam int unsigned XY_W = 15;
  localparam int unsigned Z_W  = 32;
  localparam int unsigned IN_W = 12;
  localparam int unsigned CD_W = 16;

  localparam logic signed [Z_W-1:0]  QUARTER_FX  = 32'sd589824000;
  localparam logic signed [Z_W-1:0]  ROUND_HALF  = 32'sd32768;
  localparam logic signed [CD_W-1:0] HALF_TURN   = 16'sd18000;
  localparam logic signed [CD_W:0]   FULL_TURN   = 17'sd36000;
  localparam logic signed [CD_W-1:0] DECL_RESET  = 16'sd1261;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
  } vec_t;

  // atan(2^-i) in units of 1/65536 centidegree, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_fx(input int unsigned i);
    logic signed [Z_W-1:0] t;
    case (i)
      0:  t = 32'sd294912000;
      1:  t = 32'sd174096719;
      2:  t = 32'sd91987925;
      3:  t = 32'sd46694507;
      4:  t = 32'sd23437865;
      5:  t = 32'sd11730358;
      6:  t = 32'sd5866610;
      7:  t = 32'sd2933484;
      8:  t = 32'sd1466764;
      9:  t = 32'sd733385;
      10: t = 32'sd366693;
      11: t = 32'sd183346;
      12: t = 32'sd91673;
      13: t = 32'sd45837;
      14: t = 32'sd22918;
      15: t = 32'sd11459;
      16: t = 32'sd5730;
      17: t = 32'sd2865;
      18: t = 32'sd1432;
      19: t = 32'sd716;
      20: t = 32'sd358;
      21: t = 32'sd179;
      22: t = 32'sd90;
      23: t = 32'sd45;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

[sv/compass_heading_from_magnetometer.sv]
// Compass heading from one magnetometer sample (x, y counts) with declination added.
// Each sample runs through a pre-rotation stage, ARCTAN_STAGES registered CORDIC
// iterations, two back-end stages (round/clamp, declination/wrap) and the output
// register, in that order. One sample is taken every cycle; the whole pipeline
// holds only while the output register and its skid entry are both full,
// including the cycle in which the skid entry moves into the output register.
// The declination register is clamped to +/-18000 as it is written and resets to 1261.
// Depends on chfm_pkg, chfm_prerot, chfm_cordic_stage, chfm_post and chfm_skid.
module compass_heading_from_magnetometer import chfm_pkg::*; #(
  parameter int unsigned ARCTAN_STAGES = ARCTAN_STAGES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic signed [CD_W-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [IN_W-1:0] mag_x_i,
  input  logic signed [IN_W-1:0] mag_y_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CD_W-1:0]        heading_centideg_o
);

  logic                   en;
  logic                   valid [0:ARCTAN_STAGES];
  vec_t                   vec   [0:ARCTAN_STAGES];
  logic                   post_valid;
  logic [CD_W-1:0]        post_heading;
  logic signed [CD_W-1:0] decl_d, decl_q;

  always_comb begin
    if (cfg_wdata_i > HALF_TURN) begin
      decl_d = HALF_TURN;
    end else if (cfg_wdata_i < -HALF_TURN) begin
      decl_d = -HALF_TURN;
    end else begin
      decl_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= DECL_RESET;
    end else if (cfg_we_i) begin
      decl_q <= decl_d;
    end
  end

  assign in_stall_o = !en;

  chfm_prerot u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mag_x_i (mag_x_i),
    .mag_y_i (mag_y_i),
    .valid_o (valid[0]),
    .data_o  (vec[0])
  );

  for (genvar i = 0; i < ARCTAN_STAGES; i++) begin : g_stage
    chfm_cordic_stage #(.STAGE(i)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[i]),
      .data_i  (vec[i]),
      .valid_o (valid[i+1]),
      .data_o  (vec[i+1])
    );
  end

  chfm_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (valid[ARCTAN_STAGES]),
    .data_i    (vec[ARCTAN_STAGES]),
    .decl_i    (decl_q),
    .valid_o   (post_valid),
    .heading_o (post_heading)
  );

  chfm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (post_valid),
    .data_i      (post_heading),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (heading_centideg_o)
  );

endmodule

[sv/chfm_prerot.sv]
// Input stage: quadrant pre-rotation of the raw sample into the right half plane.
// Depends on chfm_pkg.
module chfm_prerot import chfm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [IN_W-1:0] mag_x_i,
  input  logic signed [IN_W-1:0] mag_y_i,
  output logic                   valid_o,
  output vec_t                   data_o
);

  logic signed [XY_W-1:0] x_ext, y_ext;
  vec_t data_d, data_q;
  logic valid_q;

  assign x_ext = XY_W'(mag_x_i);
  assign y_ext = XY_W'(mag_y_i);

  always_comb begin
    data_d.zero = (mag_x_i == '0) && (mag_y_i == '0);
    data_d.x    = x_ext;
    data_d.y    = y_ext;
    data_d.z    = '0;
    if (mag_x_i[IN_W-1]) begin
      if (!mag_y_i[IN_W-1]) begin
        data_d.x = y_ext;
        data_d.y = -x_ext;
        data_d.z = QUARTER_FX;
      end else begin
        data_d.x = -y_ext;
        data_d.y = x_ext;
        data_d.z = -QUARTER_FX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/chfm_cordic_stage.sv]
// One registered vectoring CORDIC iteration with a fixed shift and table angle.
// Depends on chfm_pkg.
module chfm_cordic_stage import chfm_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  vec_t data_i,
  output logic valid_o,
  output vec_t data_o
);

  localparam logic signed [Z_W-1:0] ANGLE = atan_fx(STAGE);

  logic signed [XY_W-1:0] dx, dy;
  vec_t data_d, data_q;
  logic valid_q;

  // arithmetic shifts floor toward minus infinity
  assign dx = data_i.y >>> STAGE;
  assign dy = data_i.x >>> STAGE;

  always_comb begin
    data_d.zero = data_i.zero;
    if (!data_i.y[XY_W-1]) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ANGLE;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/chfm_post.sv]
// Back end: round and clamp the angle, then add declination and wrap into 0..36000.
// Two register stages; depends on chfm_pkg.
module chfm_post import chfm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  vec_t                   data_i,
  input  logic signed [CD_W-1:0] decl_i,
  output logic                   valid_o,
  output logic [CD_W-1:0]        heading_o
);

  logic signed [Z_W-1:0]  z_rnd;
  logic signed [CD_W-1:0] ang_rnd;
  logic signed [CD_W-1:0] ang_d, ang_q;
  logic signed [CD_W:0]   sum;
  logic signed [CD_W:0]   wrap;
  logic [CD_W-1:0]        head_d, head_q;
  logic                   va_q, vb_q;

  assign z_rnd   = data_i.z + ROUND_HALF;
  assign ang_rnd = z_rnd[Z_W-1:Z_W-CD_W];

  always_comb begin
    if (data_i.zero) begin
      ang_d = '0;
    end else if (ang_rnd > HALF_TURN) begin
      ang_d = HALF_TURN;
    end else if (ang_rnd < -HALF_TURN) begin
      ang_d = -HALF_TURN;
    end else begin
      ang_d = ang_rnd;
    end
  end

  assign sum = {ang_q[CD_W-1], ang_q} + {decl_i[CD_W-1], decl_i};

  // exactly a full turn is kept as is
  always_comb begin
    if (sum[CD_W]) begin
      wrap = sum + FULL_TURN;
    end else if (sum > FULL_TURN) begin
      wrap = sum - FULL_TURN;
    end else begin
      wrap = sum;
    end
    head_d = wrap[CD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q  <= ang_d;
      head_q <= head_d;
    end
  end

  assign valid_o   = vb_q;
  assign heading_o = head_q;

endmodule

[sv/chfm_skid.sv]
// Output register with one skid entry; holds the pipeline when both are full.
// Depends on chfm_pkg.
module chfm_skid import chfm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [CD_W-1:0] data_i,
  output logic            en_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CD_W-1:0] data_o
);

  logic            out_valid_q, sk_valid_q;
  logic [CD_W-1:0] out_data_q, sk_data_q;
  logic            take, pop;

  assign en_o = !sk_valid_q;
  assign take = en_o && valid_i;
  assign pop  = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (sk_valid_q) begin
      if (pop) begin
        sk_valid_q <= 1'b0;
      end
    end else if (take) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        sk_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (pop) begin
        out_data_q <= sk_data_q;
      end
    end else if (take) begin
      if (!out_valid_q || pop) begin
        out_data_q <= data_i;
      end else begin
        sk_data_q <= data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;

endmodule

[sv/chfm_checker.sv]
// Port-level checks for the compass heading block, bound to the top level.
// Depends on chfm_pkg and compass_heading_from_magnetometer.
module chfm_checker import chfm_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [CD_W-1:0]        heading_centideg_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(heading_centideg_o))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_centideg_o <= 16'd36000)
    else $error("heading out of range");

  // input side holds only while the output register is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output stall");

  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall not released after transfer out");

endmodule

bind compass_heading_from_magnetometer chfm_checker u_chfm_checker (.*);
